### rtl/sha1he_pkg.sv
// shared types and constants of the sha-1 engine
`timescale 1ns / 1ps
`default_nettype none
package sha1he_pkg;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] IV [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [6:0] LAST_ROUND  = 7'd79;
    localparam logic [2:0] LAST_INDEX  = 3'd4;

    typedef struct packed {
        logic       put_byte;   // write the incoming byte and count it
        logic       pad;        // write the marker byte and zero later words
        logic       len_wr;     // write the bit length into words 14 and 15
        logic       clear_all;  // with len_wr: zero words 0 to 13
        logic       round;      // run one compression round
        logic       add_chain;  // fold working variables into the chain
        logic       init;       // back to the initial chain, count zero
        logic [6:0] rnd;
        logic [2:0] out_idx;
    } cmd_t;

    typedef struct packed {
        logic [5:0] pos;        // byte position within the block
    } status_t;

endpackage
`default_nettype wire

### rtl/sha1he_datapath.sv
// sha-1 datapath: block buffer and schedule, round unit, chain and length
`timescale 1ns / 1ps
`default_nettype none
module sha1he_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        data_byte,
    input  wire sha1he_pkg::cmd_t  cmd,
    output sha1he_pkg::status_t    status,
    output logic [31:0]            digest_word
);

    logic [31:0] buf_reg   [16];
    logic [31:0] buf_next  [16];
    logic [31:0] wv_reg    [5];
    logic [31:0] wv_next   [5];
    logic [31:0] chain_reg [5];
    logic [31:0] chain_next[5];
    logic [63:0] count_reg, count_next;

    logic [31:0] a, b, c, d, e, f, k, w_new, t_sum;
    logic [7:0]  wr_byte;
    logic [5:0]  pos;
    logic [3:0]  wi;
    logic [4:0]  sh;
    logic [63:0] bits;

    assign pos    = count_reg[5:0];
    assign wi     = pos[5:2];
    assign sh     = {~pos[1:0], 3'b000};
    assign wr_byte = cmd.pad ? sha1he_pkg::PAD_BYTE : data_byte;
    assign bits   = {count_reg[60:0], 3'b000};
    assign status.pos = pos;
    assign digest_word = chain_reg[cmd.out_idx];

    // first round starts from the chain value
    always_comb begin
        if (cmd.rnd == 7'd0) begin
            a = chain_reg[0]; b = chain_reg[1]; c = chain_reg[2];
            d = chain_reg[3]; e = chain_reg[4];
        end else begin
            a = wv_reg[0]; b = wv_reg[1]; c = wv_reg[2];
            d = wv_reg[3]; e = wv_reg[4];
        end
        if (cmd.rnd < 7'd20) begin
            f = (b & c) | (~b & d);
            k = sha1he_pkg::K0;
        end else if (cmd.rnd < 7'd40) begin
            f = b ^ c ^ d;
            k = sha1he_pkg::K1;
        end else if (cmd.rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1he_pkg::K2;
        end else begin
            f = b ^ c ^ d;
            k = sha1he_pkg::K3;
        end
        t_sum = {a[26:0], a[31:27]} + f + e + buf_reg[0] + k;
    end

    assign w_new = {buf_reg[13][30:0] ^ buf_reg[8][30:0] ^ buf_reg[2][30:0]
                    ^ buf_reg[0][30:0],
                    buf_reg[13][31] ^ buf_reg[8][31] ^ buf_reg[2][31] ^ buf_reg[0][31]};

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            buf_next[i] = buf_reg[i];
            if (cmd.round) begin
                buf_next[i] = (i == 15) ? w_new : buf_reg[(i + 1) % 16];
            end else if (cmd.put_byte || cmd.pad) begin
                if (4'(i) == wi) begin
                    buf_next[i] = ((pos[1:0] == 2'd0) ? 32'd0 : buf_reg[i])
                                  | ({24'd0, wr_byte} << sh);
                end else if (cmd.pad && 4'(i) > wi) begin
                    buf_next[i] = 32'd0;
                end
            end else if (cmd.len_wr) begin
                if (i == 14)      buf_next[i] = bits[63:32];
                else if (i == 15) buf_next[i] = bits[31:0];
                else if (cmd.clear_all) buf_next[i] = 32'd0;
            end
        end
        wv_next[0] = cmd.round ? t_sum : wv_reg[0];
        wv_next[1] = cmd.round ? a : wv_reg[1];
        wv_next[2] = cmd.round ? {b[1:0], b[31:2]} : wv_reg[2];
        wv_next[3] = cmd.round ? c : wv_reg[3];
        wv_next[4] = cmd.round ? d : wv_reg[4];
        for (int i = 0; i < 5; i++) begin
            chain_next[i] = chain_reg[i];
            if (cmd.init)           chain_next[i] = sha1he_pkg::IV[i];
            else if (cmd.add_chain) chain_next[i] = chain_reg[i] + wv_reg[i];
        end
        count_next = count_reg;
        if (cmd.init)          count_next = 64'd0;
        else if (cmd.put_byte) count_next = count_reg + 64'd1;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) buf_reg[i] <= buf_next[i];
        for (int i = 0; i < 5; i++)  wv_reg[i]  <= wv_next[i];
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) chain_reg[i] <= sha1he_pkg::IV[i];
            count_reg <= 64'd0;
        end else begin
            for (int i = 0; i < 5; i++) chain_reg[i] <= chain_next[i];
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

### rtl/sha1he_ctrl.sv
// sha-1 controller: byte intake, round sequencing, padding and digest output
`timescale 1ns / 1ps
`default_nettype none
module sha1he_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic                 has_byte,
    input  wire logic                 end_msg,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire sha1he_pkg::status_t  status,
    output sha1he_pkg::cmd_t          cmd
);

    typedef enum logic [2:0] {S_IDLE, S_ROUND, S_ADD, S_PAD, S_LEN, S_OUT} state_t;
    typedef enum logic [1:0] {PH_BYTE, PH_PADFULL, PH_LEN} phase_t;

    state_t     state_reg;
    phase_t     phase_reg;
    logic [6:0] rnd_reg;
    logic [2:0] idx_reg;
    logic       fin_reg, full_reg;
    logic       acc;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        cmd           = '0;
        cmd.rnd       = rnd_reg;
        cmd.out_idx   = idx_reg;
        cmd.put_byte  = acc && has_byte;
        cmd.pad       = (state_reg == S_PAD);
        cmd.len_wr    = (state_reg == S_LEN);
        cmd.clear_all = full_reg;
        cmd.round     = (state_reg == S_ROUND);
        cmd.add_chain = (state_reg == S_ADD);
        cmd.init      = m_tvalid && m_tready && (idx_reg == sha1he_pkg::LAST_INDEX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_BYTE;
            rnd_reg   <= 7'd0;
            idx_reg   <= 3'd0;
            fin_reg   <= 1'b0;
            full_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (acc) begin
                        fin_reg   <= end_msg;
                        phase_reg <= PH_BYTE;
                        rnd_reg   <= 7'd0;
                        // a byte that fills the block is compressed first
                        if (has_byte && status.pos == 6'd63) state_reg <= S_ROUND;
                        else if (end_msg)                     state_reg <= S_PAD;
                    end
                end
                S_ROUND: begin
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == sha1he_pkg::LAST_ROUND) state_reg <= S_ADD;
                end
                S_ADD: begin
                    rnd_reg <= 7'd0;
                    unique case (phase_reg)
                        PH_BYTE:    state_reg <= fin_reg ? S_PAD : S_IDLE;
                        PH_PADFULL: begin
                            full_reg  <= 1'b1;
                            state_reg <= S_LEN;
                        end
                        default: begin
                            idx_reg   <= 3'd0;
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_PAD: begin
                    rnd_reg <= 7'd0;
                    // no room left for the length in this block
                    if (status.pos[5:3] == 3'b111) begin
                        phase_reg <= PH_PADFULL;
                        state_reg <= S_ROUND;
                    end else begin
                        full_reg  <= 1'b0;
                        state_reg <= S_LEN;
                    end
                end
                S_LEN: begin
                    phase_reg <= PH_LEN;
                    rnd_reg   <= 7'd0;
                    state_reg <= S_ROUND;
                end
                S_OUT: begin
                    if (m_tready) begin
                        if (idx_reg == sha1he_pkg::LAST_INDEX) begin
                            idx_reg   <= 3'd0;
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/sha1_hash_engine_core.sv
// sha-1 engine top level: byte stream in, five digest words out
//
//  channel | dir | tdata             | tuser          | tlast
//  s_      | in  | data_byte [7:0]   | has_byte       | end_of_message
//  m_      | out | digest_word[31:0] | word_index[2:0]| last_word
//
// a byte beat is taken while idle; a block that fills is then compressed
// (80 rounds on one shared round unit, one chain add)
// an end beat adds padding and one or two compressions, then five output beats
// input is not taken while compressing, padding or sending the digest
// aresetn is synchronous; afterwards the engine is ready at once
`timescale 1ns / 1ps
`default_nettype none
module sha1_hash_engine_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tuser,   // has_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // digest_word
    output logic [2:0]       m_tuser,   // word_index
    output logic             m_tlast
);

    sha1he_pkg::cmd_t    cmd;
    sha1he_pkg::status_t status;

    sha1he_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .has_byte (s_tuser),
        .end_msg  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sha1he_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .data_byte   (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .digest_word (m_tdata)
    );

    assign m_tuser = cmd.out_idx;
    assign m_tlast = (cmd.out_idx == sha1he_pkg::LAST_INDEX);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input taken while digest pending");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= sha1he_pkg::LAST_INDEX)) else $error("bad word index");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("digest did not end after last word");

    a_word_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
        else $error("digest words out of order");

endmodule
`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the byte-serial sha-1 engine
`timescale 1ns / 1ps
module tb_top;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_msg;
    } beat_in_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    localparam int CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0] m_tuser;
    logic m_tlast;

    sha1_hash_engine_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // predictor state
    logic [31:0] chain [5];
    logic [31:0] blk [16];
    logic [63:0] msg_bytes;

    beat_in_t     pending_beats [$];
    digest_beat_t expected_words [$];
    int mismatches = 0;
    int words_seen = 0;
    int messages_sent = 0;
    int items_queued = 0;
    longint cycles = 0;
    int long_stall = 0;

    function automatic logic [31:0] rol(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = sha1he_pkg::K0;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = sha1he_pkg::K1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = sha1he_pkg::K2;
            end else begin
                f = b ^ c ^ d; k = sha1he_pkg::K3;
            end
            t = rol(a, 5) + f + e + w[i] + k;
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic place_byte(input int pos, input logic [7:0] v);
        if (pos % 4 == 0) blk[pos / 4] = '0;
        blk[pos / 4] |= 32'(v) << ((3 - pos % 4) * 8);
    endtask

    task automatic restart_message();
        for (int i = 0; i < 5; i++) chain[i] = sha1he_pkg::IV[i];
        msg_bytes = '0;
    endtask

    task automatic predict_digest(input beat_in_t bt);
        int pos;
        logic [63:0] bits;
        digest_beat_t dw;
        if (bt.has_byte) begin
            pos = int'(msg_bytes[5:0]);
            place_byte(pos, bt.data_byte);
            msg_bytes++;
            if (pos == 63) compress_block();
        end
        if (!bt.end_msg) return;
        pos = int'(msg_bytes[5:0]);
        place_byte(pos, sha1he_pkg::PAD_BYTE);
        for (int i = pos / 4 + 1; i < 16; i++) blk[i] = '0;
        if (pos >= 56) begin
            compress_block();
            for (int i = 0; i < 16; i++) blk[i] = '0;
        end
        bits = msg_bytes << 3;
        blk[14] = bits[63:32];
        blk[15] = bits[31:0];
        compress_block();
        for (int i = 0; i < 5; i++) begin
            dw.word = chain[i];
            dw.idx = 3'(i);
            dw.last = (i == 4);
            expected_words.push_back(dw);
        end
        restart_message();
    endtask

    task automatic queue_beat(input logic [7:0] v, input logic hb, input logic em);
        beat_in_t bt;
        bt.data_byte = v; bt.has_byte = hb; bt.end_msg = em;
        pending_beats.push_back(bt);
        items_queued++;
    endtask

    // well-formed message of n bytes with random content and the odd empty beat
    task automatic queue_message(input int n, input bit end_with_byte);
        for (int i = 0; i < n - (end_with_byte ? 1 : 0); i++) begin
            if ($urandom_range(0, 15) == 0) queue_beat(8'($urandom), 1'b0, 1'b0);
            queue_beat(8'($urandom), 1'b1, 1'b0);
        end
        queue_beat(8'($urandom), end_with_byte && n > 0, 1'b1);
    endtask

    // driver: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_digest(pending_beats.pop_front());
                if (burst_left > 0) burst_left--;
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (burst_left == 0 && !(s_tvalid && !s_tready)) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 12);
            end
            if (pending_beats.size() > 0 && gap_left == 0) begin
                s_tvalid <= 1'b1;
                {s_tdata, s_tuser, s_tlast} <= pending_beats[0];
            end else if (!(s_tvalid && !s_tready) || pending_beats.size() == 0) begin
                s_tvalid <= 1'b0;
                s_tdata <= 8'($urandom);
                s_tuser <= 1'($urandom);
                s_tlast <= 1'b0;
            end
        end
    end

    // receiver stall pattern plus one long hold-off
    logic [7:0] stall_pattern = 8'b1011_0110;
    int pat_pos = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_stall > 0) begin
            long_stall <= long_stall - 1;
            m_tready <= 1'b0;
        end else begin
            pat_pos <= (pat_pos + 1) % 64;
            if (pat_pos < 24) m_tready <= 1'b1;
            else m_tready <= stall_pattern[pat_pos % 8] | 1'($urandom_range(0, 1));
        end
    end

    // monitor
    always @(posedge aclk) begin
        digest_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest beat %h idx %0d last %b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                want = expected_words.pop_front();
                if (m_tdata !== want.word || m_tuser !== want.idx || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 want.word, want.idx, want.last, m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("sha1_hash_engine_core verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_beats.size() > 0 || expected_words.size() > 0) @(posedge aclk);
    endtask

    initial begin
        int n;
        restart_message();
        for (int i = 0; i < 16; i++) blk[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty message, lone byte ends, idle beats
        queue_beat(8'hFF, 1'b0, 1'b0);
        queue_beat(8'h00, 1'b0, 1'b1);
        queue_beat(8'hFF, 1'b1, 1'b1);
        queue_beat(8'h00, 1'b1, 1'b1);
        queue_beat(8'h61, 1'b1, 1'b0);
        queue_beat(8'h62, 1'b1, 1'b0);
        queue_beat(8'h63, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b0, 1'b1);
        queue_beat(8'hAA, 1'b1, 1'b0);
        queue_beat(8'h55, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b0, 1'b0);
        queue_beat(8'h80, 1'b1, 1'b1);
        wait_drained();

        // lengths around the one- and two-block padding boundaries
        queue_message(55, 1);
        queue_message(56, 0);
        queue_message(64, 1);

        // long hold-off on the result side while input keeps coming
        long_stall = 600;
        queue_message(3, 0);
        queue_message(2, 1);
        queue_message(1, 0);
        wait_drained();
        messages_sent += 11;

        // random part
        while (items_queued < 230) begin
            n = $urandom_range(0, 12);
            if ($urandom_range(0, 9) == 0) queue_beat(8'($urandom), 1'b0, 1'b0);
            queue_message(n, $urandom_range(0, 1));
            messages_sent++;
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        wait_drained();
        repeat (200) @(posedge aclk);

        $display("covered %0d messages incl. empty, padding-boundary and stalled cases",
                 messages_sent);
        $display("checked %0d digest words, %0d mismatches", words_seen, mismatches);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("sha1_hash_engine_core verification clean");
        else
            $display("sha1_hash_engine_core verification failed");
        $finish;
    end
endmodule
